/* hw/rtl/ipid_pkg.sv */
`timescale 1ns / 1ps

package ipid_pkg;

  localparam int DEF_GAIN_FRAC_BITS = 8;
  localparam int DEF_SPEED_WIDTH    = 16;

  localparam int GAIN_W    = 16;
  localparam int PWM_W     = 16;
  localparam int ACC_W     = 40;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam int ILIM_INT = 300;
  localparam int TOP_INT  = 1000;

  localparam logic [PWM_W-1:0] LIMIT_RESET = PWM_W'(1000);

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE  = CFG_IDX_W'(4);

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [PWM_W-1:0]  output_limit;
    logic              loop_enable;
  } ipid_cfg_t;

endpackage

/* hw/rtl/ipid_cfg_regs.sv */
`timescale 1ns / 1ps

module ipid_cfg_regs import ipid_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  output ipid_cfg_t            cfg_o
);

  ipid_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN_P:       cfg_d.gain_p       = cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_I:       cfg_d.gain_i       = cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_D:       cfg_d.gain_d       = cfg_wdata_i[GAIN_W-1:0];
        REG_OUTPUT_LIMIT: cfg_d.output_limit = cfg_wdata_i[PWM_W-1:0];
        REG_LOOP_ENABLE:  cfg_d.loop_enable  = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p       <= '0;
      cfg_q.gain_i       <= '0;
      cfg_q.gain_d       <= '0;
      cfg_q.output_limit <= LIMIT_RESET;
      cfg_q.loop_enable  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/incremental_pid_anti_windup.sv */
`timescale 1ns / 1ps

// Velocity-form PID speed controller with integral anti-windup. Each input transfer carries a
// target and a measured speed; each produces exactly one pwm_duty transfer, in order. The block
// takes one transfer per clock unless the output stalls. The first register stage holds the
// three gain products (proportional and derivative summed, integral clamped to +/-300), the
// second folds them into the 40-bit accumulator (8 fraction bits by default, saturating) and
// clamps the integer part to 0..output_limit, or 0 when the target is zero. Gains are unsigned
// Q8.8. With loop_enable at 0 the state is frozen and the last duty value repeats. Users must
// write registers via the plain cfg port only with no transfer in flight; it is not checked.

module incremental_pid_anti_windup import ipid_pkg::*; #(
  parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS,
  parameter int SPEED_WIDTH    = DEF_SPEED_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // target_speed, measured_speed
  input  logic [((2*SPEED_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // pwm_duty
  output logic [PWM_W-1:0]     m_axis_tdata
);

  localparam int GS_W  = GAIN_W + 1;
  localparam int ERR_W = SPEED_WIDTH + 1;
  localparam int D1_W  = SPEED_WIDTH + 2;
  localparam int D2_W  = SPEED_WIDTH + 3;
  localparam int PP_W  = GS_W + D1_W;
  localparam int PD_W  = GS_W + D2_W;
  localparam int I_W   = GS_W + ERR_W;
  localparam int SUM_W = ((ACC_W > PD_W) ? ACC_W : PD_W) + 2;
  localparam int IP_W  = ACC_W - GAIN_FRAC_BITS;
  localparam int ILIM  = ILIM_INT * (1 << GAIN_FRAC_BITS);
  localparam int TOP   = TOP_INT * (1 << GAIN_FRAC_BITS);

  localparam logic signed [I_W-1:0]   ILIM_P  = I_W'(ILIM);
  localparam logic signed [I_W-1:0]   ILIM_N  = -I_W'(ILIM);
  localparam logic signed [SUM_W-1:0] TOP_S   = SUM_W'(TOP);
  localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'({1'b0, {(ACC_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] ACC_MIN = -SUM_W'({1'b1, {(ACC_W-1){1'b0}}});

  ipid_cfg_t cfg;

  ipid_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // handshake
  logic v0_q, vo_q;
  logic adv_out, in_xfer, s0_move;

  assign adv_out       = !vo_q || m_axis_tready;
  assign s_axis_tready = !v0_q || adv_out;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s0_move       = v0_q && adv_out;

  // stage 0: error, products
  logic signed [SPEED_WIDTH-1:0] tgt, meas;
  logic signed [ERR_W-1:0] err, e1_q, e2_q;
  logic signed [D1_W-1:0]  d1;
  logic signed [D2_W-1:0]  d2;
  logic signed [GS_W-1:0]  gp_s, gi_s, gd_s;
  logic signed [PP_W-1:0]  pp;
  logic signed [PD_W-1:0]  pdd;
  logic signed [I_W-1:0]   ip, ic;
  logic signed [SUM_W-1:0] pd_d, pd_q;
  logic signed [I_W-1:0]   integ_q;
  logic                    zero_q, en_q;

  assign tgt  = s_axis_tdata[SPEED_WIDTH-1:0];
  assign meas = s_axis_tdata[2*SPEED_WIDTH-1:SPEED_WIDTH];
  assign err  = ERR_W'(tgt) - ERR_W'(meas);
  assign d1   = D1_W'(err) - D1_W'(e1_q);
  assign d2   = D2_W'(err) - (D2_W'(e1_q) <<< 1) + D2_W'(e2_q);
  assign gp_s = $signed({1'b0, cfg.gain_p});
  assign gi_s = $signed({1'b0, cfg.gain_i});
  assign gd_s = $signed({1'b0, cfg.gain_d});
  assign pp   = PP_W'(gp_s) * PP_W'(d1);
  assign pdd  = PD_W'(gd_s) * PD_W'(d2);
  assign ip   = I_W'(gi_s) * I_W'(err);
  assign ic   = (ip > ILIM_P) ? ILIM_P : ((ip < ILIM_N) ? ILIM_N : ip);
  assign pd_d = SUM_W'(pp) + SUM_W'(pdd);

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pd_q    <= pd_d;
      integ_q <= ic;
      zero_q  <= (tgt == '0);
      en_q    <= cfg.loop_enable;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      e1_q <= '0;
      e2_q <= '0;
    end else begin
      if (in_xfer) begin
        v0_q <= 1'b1;
      end else if (s0_move) begin
        v0_q <= 1'b0;
      end
      if (in_xfer && cfg.loop_enable) begin
        e2_q <= e1_q;
        e1_q <= err;
      end
    end
  end

  // stage 1: accumulator with anti-windup, duty clamp
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [SUM_W-1:0] integ_s, delta, pred, step, acc_sum;
  logic        [IP_W-1:0]  ipart;
  logic        [PWM_W-1:0] pwm_d, pwm_hold_q;

  assign integ_s = SUM_W'(integ_q);
  assign delta   = pd_q + integ_s;
  assign pred    = SUM_W'(acc_q) + delta;

  always_comb begin
    if (pred > TOP_S) begin
      step = (integ_q < 0) ? delta : pd_q;
    end else if (pred < 0) begin
      step = (integ_q > 0) ? delta : pd_q;
    end else begin
      step = delta;
    end
    acc_sum = SUM_W'(acc_q) + step;
    if (acc_sum > ACC_MAX) begin
      acc_d = ACC_W'(ACC_MAX);
    end else if (acc_sum < ACC_MIN) begin
      acc_d = ACC_W'(ACC_MIN);
    end else begin
      acc_d = ACC_W'(acc_sum);
    end
    ipart = acc_d[ACC_W-1:GAIN_FRAC_BITS];
    if (acc_d < 0 || zero_q) begin
      pwm_d = '0;
    end else if (ipart > IP_W'(cfg.output_limit)) begin
      pwm_d = cfg.output_limit;
    end else begin
      pwm_d = ipart[PWM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q       <= 1'b0;
      acc_q      <= '0;
      pwm_hold_q <= '0;
    end else begin
      if (adv_out) begin
        vo_q <= v0_q;
      end
      if (s0_move && en_q) begin
        acc_q      <= acc_d;
        pwm_hold_q <= pwm_d;
      end
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = pwm_hold_q;

endmodule

/* verif/incremental_pid_anti_windup_tb.sv */
`timescale 1ns / 1ps

module incremental_pid_anti_windup_tb;
  import ipid_pkg::*;

  localparam int FRAC   = DEF_GAIN_FRAC_BITS;
  localparam int SPD_W  = DEF_SPEED_WIDTH;
  localparam int DATA_W = ((2 * SPD_W + 7) / 8) * 8;
  localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_LOOP_ENABLE + 1;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 200;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [PWM_W-1:0]     m_axis_tdata;

  // controller mirror
  logic [15:0]      ctl_gain_p, ctl_gain_i, ctl_gain_d, ctl_limit;
  logic             ctl_enable;
  longint           ctl_acc, ctl_err1, ctl_err2;
  logic [PWM_W-1:0] ctl_hold;

  logic [DATA_W-1:0] speed_queue[$];
  logic [PWM_W-1:0]  duty_expected[$];
  int send_idle_pct = 25;
  int recv_stall_pct = 67;
  int fail_count = 0;

  incremental_pid_anti_windup dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [PWM_W-1:0] next_duty(logic [SPD_W-1:0] tgt_raw,
                                                 logic [SPD_W-1:0] meas_raw);
    longint tgt, err, integ, pd, delta, pred, ilim, top, ipart, nacc;
    logic [PWM_W-1:0] duty;
    if (!ctl_enable) return ctl_hold;
    tgt   = longint'($signed(tgt_raw));
    err   = tgt - longint'($signed(meas_raw));
    ilim  = longint'(ILIM_INT) <<< FRAC;
    top   = longint'(TOP_INT) <<< FRAC;
    integ = longint'(ctl_gain_i) * err;
    if (integ > ilim) integ = ilim;
    if (integ < -ilim) integ = -ilim;
    pd = longint'(ctl_gain_p) * (err - ctl_err1)
       + longint'(ctl_gain_d) * (err - 2 * ctl_err1 + ctl_err2);
    delta = pd + integ;
    pred  = ctl_acc + delta;
    // anti-windup: keep I only when it pulls back toward range
    if (pred > top) nacc = ctl_acc + ((integ < 0) ? delta : pd);
    else if (pred < 0) nacc = ctl_acc + ((integ > 0) ? delta : pd);
    else nacc = pred;
    if (nacc > ACC_HI) nacc = ACC_HI;
    if (nacc < ACC_LO) nacc = ACC_LO;
    ctl_acc  = nacc;
    ctl_err2 = ctl_err1;
    ctl_err1 = err;
    if (ctl_acc < 0) begin
      duty = '0;
    end else begin
      ipart = ctl_acc >>> FRAC;
      if (ipart > longint'(ctl_limit)) duty = ctl_limit;
      else duty = ipart[PWM_W-1:0];
    end
    if (tgt == 0) duty = '0;
    ctl_hold = duty;
    return duty;
  endfunction

  function automatic logic [15:0] pick_gain();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'hFFFF;
    if (r < 80) return 16'($urandom_range(0, 1024));
    return 16'($urandom);
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_GAIN_P:       ctl_gain_p = val;
      REG_GAIN_I:       ctl_gain_i = val;
      REG_GAIN_D:       ctl_gain_d = val;
      REG_OUTPUT_LIMIT: ctl_limit  = val;
      REG_LOOP_ENABLE:  ctl_enable = val[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_speeds(shortint tgt, shortint meas);
    speed_queue.push_back({meas, tgt});
  endtask

  task automatic wait_idle();
    while (speed_queue.size() != 0 || s_axis_tvalid || duty_expected.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (speed_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= speed_queue.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    logic [PWM_W-1:0] want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        duty_expected.push_back(next_duty(s_axis_tdata[SPD_W-1:0],
                                          s_axis_tdata[2*SPD_W-1:SPD_W]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (duty_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected pwm_duty transfer: got %0d", m_axis_tdata);
        end else begin
          want = duty_expected.pop_front();
          if (m_axis_tdata !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("pwm_duty mismatch: expected %0d, got %0d", want, m_axis_tdata);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("incremental_pid_anti_windup_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    int r, set_point;
    shortint tgt, meas;
    ctl_gain_p = '0;
    ctl_gain_i = '0;
    ctl_gain_d = '0;
    ctl_limit  = LIMIT_RESET;
    ctl_enable = 1'b1;
    ctl_acc    = 0;
    ctl_err1   = 0;
    ctl_err2   = 0;
    ctl_hold   = '0;
    set_point  = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: all gains zero
    push_speeds(100, 50);
    push_speeds(0, 0);
    wait_idle();

    cfg_write(REG_GAIN_P, 16'h0100);
    cfg_write(REG_GAIN_I, 16'h0040);
    cfg_write(REG_GAIN_D, 16'h0080);
    cfg_write(REG_OUTPUT_LIMIT, 16'd1000);
    cfg_write(REG_UNUSED, 16'hFFFF);
    push_speeds(500, 0);
    push_speeds(500, 100);
    push_speeds(500, 400);
    push_speeds(500, 500);
    push_speeds(32767, -32768);
    push_speeds(-32768, 32767);
    push_speeds(0, 123);
    push_speeds(0, -123);
    push_speeds(32767, 32767);
    push_speeds(-32768, -32768);
    push_speeds(-1, 0);
    push_speeds(1000, -1000);
    push_speeds(200, 190);
    push_speeds(200, 210);
    push_speeds(-300, -290);
    wait_idle();

    // frozen loop repeats last duty
    cfg_write(REG_LOOP_ENABLE, 16'd0);
    push_speeds(700, 0);
    push_speeds(0, 0);
    push_speeds(-5, 3);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 25;
        recv_stall_pct = 67;
      end else if (ph < 6) begin
        send_idle_pct = 67;
        recv_stall_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if (ph == 0) begin
        cfg_write(REG_GAIN_P, 16'hFFFF);
        cfg_write(REG_GAIN_I, 16'hFFFF);
        cfg_write(REG_GAIN_D, 16'hFFFF);
        cfg_write(REG_OUTPUT_LIMIT, 16'hFFFF);
      end else if (ph == 1) begin
        cfg_write(REG_GAIN_P, 16'd0);
        cfg_write(REG_GAIN_I, 16'd0);
        cfg_write(REG_GAIN_D, 16'd0);
        cfg_write(REG_OUTPUT_LIMIT, 16'd0);
      end else begin
        cfg_write(REG_GAIN_P, pick_gain());
        cfg_write(REG_GAIN_I, pick_gain());
        cfg_write(REG_GAIN_D, pick_gain());
        r = $urandom_range(3);
        cfg_write(REG_OUTPUT_LIMIT, (r == 0) ? 16'd1000 : (r == 1) ? 16'hFFFF :
                  16'($urandom_range(1, 2000)));
      end
      cfg_write(REG_LOOP_ENABLE, (ph == 4) ? 16'd0 : 16'd1);
      cfg_write(REG_UNUSED + CFG_IDX_W'($urandom_range(0, 2)), 16'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 8) begin
          tgt  = 0;
          meas = shortint'(int'($urandom_range(0, 400)) - 200);
        end else if (r < 28) begin
          tgt  = shortint'($urandom);
          meas = shortint'($urandom);
        end else begin
          if ($urandom_range(19) == 0) set_point = int'($urandom_range(0, 3000)) - 1500;
          tgt  = shortint'(set_point);
          meas = shortint'(set_point + int'($urandom_range(0, 200)) - 100);
        end
        push_speeds(tgt, meas);
      end
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    fail_count += duty_expected.size();
    if (fail_count == 0) begin
      $display("incremental_pid_anti_windup_tb: PASS");
    end else begin
      $display("incremental_pid_anti_windup_tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/ipid_pkg.sv
hw/rtl/ipid_cfg_regs.sv
hw/rtl/incremental_pid_anti_windup.sv
verif/incremental_pid_anti_windup_tb.sv
